[hw/rtl/lfid_pkg.sv]
// ============================================================================
// lfid_pkg: shared definitions for the lowest-free identifier allocator
// Sizes of the free bitmap, identifier widths, sequencer states and the
// structures that pass between the allocator's modules.
// ============================================================================
package lfid_pkg;

    localparam int WORD_BITS = 64;
    localparam int MAX_WORDS = 16;

    localparam int ID_W   = 10;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int WIDX_W = $clog2(MAX_WORDS);
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int IDF_W  = CNT_W + BIT_W;

    localparam int GRP_BITS   = 8;
    localparam int NUM_GRPS   = (WORD_BITS + GRP_BITS - 1) / GRP_BITS;
    localparam int PAD_W      = NUM_GRPS * GRP_BITS;
    localparam int GRP_IDX_W  = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;
    localparam int GRP_POS_W  = $clog2(GRP_BITS);

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;

    localparam word_t NEW_WORD = ~word_t'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_READ,
        ST_A_WAIT,
        ST_A_FFS,
        ST_A_NEW,
        ST_R_READ,
        ST_R_WAIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [WIDX_W-1:0] addr;
        word_t             wdata;
    } ram_req_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } ffs_res_t;

    function automatic word_t bit_mask(input logic [BIT_W-1:0] pos);
        return word_t'(1) << pos;
    endfunction

    function automatic logic [ID_W-1:0] make_id(input logic [WIDX_W-1:0] widx,
                                                 input logic [BIT_W-1:0]  pos);
        logic [IDF_W-1:0] full;
        full = IDF_W'(widx) * IDF_W'(WORD_BITS) + IDF_W'(pos);
        return full[ID_W-1:0];
    endfunction

endpackage

[hw/rtl/lfid_ram.sv]
// ============================================================================
// lfid_ram: free bitmap storage
// Single-port memory of bitmap words with a registered read.
// ============================================================================
module lfid_ram (
    input  logic               clk,
    input  lfid_pkg::ram_req_t req,
    output lfid_pkg::word_t    rdata
);

    lfid_pkg::word_t mem [lfid_pkg::MAX_WORDS];
    lfid_pkg::word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/lfid_ffs.sv]
// ============================================================================
// lfid_ffs: lowest set bit search
// Registers a bitmap word together with its first non-empty byte group, then
// resolves the bit position inside that group.
// ============================================================================
module lfid_ffs (
    input  logic               clk,
    input  logic               load,
    input  lfid_pkg::word_t    word,
    output lfid_pkg::ffs_res_t res,
    output lfid_pkg::word_t    word_out
);

    logic [lfid_pkg::PAD_W-1:0]     pad_next;
    logic [lfid_pkg::PAD_W-1:0]     pad_reg;
    logic [lfid_pkg::NUM_GRPS-1:0]  grp_any;
    logic [lfid_pkg::GRP_IDX_W-1:0] grp_next;
    logic [lfid_pkg::GRP_IDX_W-1:0] grp_reg;
    logic                           found_next;
    logic                           found_reg;
    logic [lfid_pkg::GRP_BITS-1:0]  sel;
    logic [lfid_pkg::GRP_POS_W-1:0] inner;

    always_comb
    begin
        pad_next = lfid_pkg::PAD_W'(word);
        for (int g = 0; g < lfid_pkg::NUM_GRPS; g++)
        begin
            grp_any[g] = |pad_next[g*lfid_pkg::GRP_BITS +: lfid_pkg::GRP_BITS];
        end
        grp_next = '0;
        for (int g = lfid_pkg::NUM_GRPS - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                grp_next = lfid_pkg::GRP_IDX_W'(g);
            end
        end
        found_next = |grp_any;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pad_reg   <= pad_next;
            grp_reg   <= grp_next;
            found_reg <= found_next;
        end
    end

    always_comb
    begin
        sel   = pad_reg[grp_reg*lfid_pkg::GRP_BITS +: lfid_pkg::GRP_BITS];
        inner = '0;
        for (int i = lfid_pkg::GRP_BITS - 1; i >= 0; i--)
        begin
            if (sel[i])
            begin
                inner = lfid_pkg::GRP_POS_W'(i);
            end
        end
        res.found = found_reg;
        res.pos   = lfid_pkg::BIT_W'(32'(grp_reg) * lfid_pkg::GRP_BITS + 32'(inner));
    end

    assign word_out = pad_reg[lfid_pkg::WORD_BITS-1:0];

endmodule

[hw/rtl/lowest_free_id_allocator.sv]
// ============================================================================
// lowest_free_id_allocator: bitmap identifier allocator, lowest free first
// Hands out and takes back small identifiers kept in a growing free bitmap.
// ============================================================================
// An allocate word scans the open bitmap words from word 0 upward through one
// single-port memory and one lowest-set-bit unit: each word is read, loaded
// into the search unit and searched, and the lowest free bit found is cleared
// in memory; with none found, a new word is opened unless the table is
// full. A release reads its word and sets the bit, or fails at once when the
// identifier lies beyond the open words. One word is in work at a time; a
// finished result waits in the output register while the next word is
// accepted. Bitmap contents need no clearing after reset, since only opened
// words are ever read.
module lowest_free_id_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [9:0] release_id, [15:10] zero
    input  logic [0:0]  s_axis_tuser,  // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [9:0] granted_id, [15:10] zero
    output logic [0:0]  m_axis_tuser   // [0] failed
);

    lfid_pkg::state_t state_reg, state_next;

    logic [lfid_pkg::CNT_W-1:0]  wiu_reg, wiu_next;
    logic [lfid_pkg::WIDX_W-1:0] addr_reg, addr_next;
    logic [lfid_pkg::BIT_W-1:0]  bit_reg, bit_next;
    logic [lfid_pkg::ID_W-1:0]   res_id_reg, res_id_next;
    logic                        res_fail_reg, res_fail_next;
    logic [lfid_pkg::ID_W-1:0]   out_id_reg, out_id_next;
    logic                        out_fail_reg, out_fail_next;
    logic                        out_valid_reg, out_valid_next;

    lfid_pkg::ram_req_t ram_req;
    lfid_pkg::word_t    ram_rdata;
    lfid_pkg::ffs_res_t ffs_res;
    lfid_pkg::word_t    ffs_word;
    logic               ffs_load;

    logic [lfid_pkg::ID_W-1:0]  rel_id;
    logic [lfid_pkg::ID_W-1:0]  rel_idx;
    logic [lfid_pkg::BIT_W-1:0] rel_bit;

    lfid_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    lfid_ffs u_ffs (
        .clk      (clk),
        .load     (ffs_load),
        .word     (ram_rdata),
        .res      (ffs_res),
        .word_out (ffs_word)
    );

    assign rel_id  = s_axis_tdata[lfid_pkg::ID_W-1:0];
    assign rel_idx = lfid_pkg::ID_W'(rel_id / lfid_pkg::WORD_BITS);
    assign rel_bit = lfid_pkg::BIT_W'(rel_id % lfid_pkg::WORD_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfid_pkg::ST_IDLE;
            wiu_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wiu_reg       <= wiu_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        bit_reg      <= bit_next;
        res_id_reg   <= res_id_next;
        res_fail_reg <= res_fail_next;
        out_id_reg   <= out_id_next;
        out_fail_reg <= out_fail_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        wiu_next       = wiu_reg;
        addr_next      = addr_reg;
        bit_next       = bit_reg;
        res_id_next    = res_id_reg;
        res_fail_next  = res_fail_reg;
        out_id_next    = out_id_reg;
        out_fail_next  = out_fail_reg;
        out_valid_next = out_valid_reg;
        ram_req        = '{rd_en: 1'b0, wr_en: 1'b0, addr: addr_reg, wdata: ffs_word};
        ffs_load       = 1'b0;
        s_axis_tready  = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lfid_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    res_id_next   = '0;
                    res_fail_next = 1'b0;
                    if (s_axis_tuser[0] == lfid_pkg::FUNC_ALLOC)
                    begin
                        addr_next = '0;
                        if (wiu_reg == '0)
                        begin
                            state_next = lfid_pkg::ST_A_NEW;
                        end
                        else
                        begin
                            state_next = lfid_pkg::ST_A_READ;
                        end
                    end
                    else if (rel_idx >= lfid_pkg::ID_W'(wiu_reg))
                    begin
                        res_fail_next = 1'b1;
                        state_next    = lfid_pkg::ST_RESP;
                    end
                    else
                    begin
                        addr_next  = lfid_pkg::WIDX_W'(rel_idx);
                        bit_next   = rel_bit;
                        state_next = lfid_pkg::ST_R_READ;
                    end
                end
            end
            lfid_pkg::ST_A_READ:
            begin
                ram_req.rd_en = 1'b1;
                state_next    = lfid_pkg::ST_A_WAIT;
            end
            lfid_pkg::ST_A_WAIT:
            begin
                ffs_load   = 1'b1;
                state_next = lfid_pkg::ST_A_FFS;
            end
            lfid_pkg::ST_A_FFS:
            begin
                if (ffs_res.found)
                begin
                    ram_req.wr_en = 1'b1;
                    ram_req.wdata = ffs_word & ~lfid_pkg::bit_mask(ffs_res.pos);
                    res_id_next   = lfid_pkg::make_id(addr_reg, ffs_res.pos);
                    state_next    = lfid_pkg::ST_RESP;
                end
                else if (lfid_pkg::CNT_W'(addr_reg) + lfid_pkg::CNT_W'(1) < wiu_reg)
                begin
                    addr_next  = addr_reg + lfid_pkg::WIDX_W'(1);
                    state_next = lfid_pkg::ST_A_READ;
                end
                else
                begin
                    state_next = lfid_pkg::ST_A_NEW;
                end
            end
            lfid_pkg::ST_A_NEW:
            begin
                if (wiu_reg < lfid_pkg::CNT_W'(lfid_pkg::MAX_WORDS))
                begin
                    ram_req.wr_en = 1'b1;
                    ram_req.addr  = lfid_pkg::WIDX_W'(wiu_reg);
                    ram_req.wdata = lfid_pkg::NEW_WORD;
                    res_id_next   = lfid_pkg::make_id(lfid_pkg::WIDX_W'(wiu_reg), '0);
                    wiu_next      = wiu_reg + lfid_pkg::CNT_W'(1);
                end
                else
                begin
                    res_fail_next = 1'b1;
                end
                state_next = lfid_pkg::ST_RESP;
            end
            lfid_pkg::ST_R_READ:
            begin
                ram_req.rd_en = 1'b1;
                state_next    = lfid_pkg::ST_R_WAIT;
            end
            lfid_pkg::ST_R_WAIT:
            begin
                if (ram_rdata[bit_reg])
                begin
                    res_fail_next = 1'b1;
                end
                else
                begin
                    ram_req.wr_en = 1'b1;
                    ram_req.wdata = ram_rdata | lfid_pkg::bit_mask(bit_reg);
                end
                state_next = lfid_pkg::ST_RESP;
            end
            lfid_pkg::ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_id_next    = res_id_reg;
                    out_fail_next  = res_fail_reg;
                    out_valid_next = 1'b1;
                    state_next     = lfid_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfid_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 16'(out_id_reg);
    assign m_axis_tuser  = out_fail_reg;

    a_wiu_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wiu_reg <= lfid_pkg::CNT_W'(lfid_pkg::MAX_WORDS))
        else $error("open word count exceeds the table size");

    a_wiu_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wiu_reg != $past(wiu_reg)) |-> (wiu_reg == $past(wiu_reg) + lfid_pkg::CNT_W'(1)))
        else $error("open word count moved by other than one");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0))
        else $error("failed result carries a nonzero identifier");

    a_grow_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (wiu_reg != $past(wiu_reg)) |-> (state_reg == lfid_pkg::ST_RESP && !res_fail_reg))
        else $error("table grew without a successful allocation");

endmodule

[tb/tb_lowest_free_id_allocator.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_lowest_free_id_allocator: self-checking bench for the identifier allocator
// Drives allocate and release words into the stream input and predicts each
// grant from a private copy of the free bitmap. Each word on the output is
// checked against the oldest prediction. The run fills the table past full,
// churns it with releases, and adds random idle bursts on both sides.
// ============================================================================

typedef struct packed {
    logic [lfid_pkg::ID_W-1:0] granted;
    logic                      failed;
} grant_t;

class id_pool_scoreboard;
    lfid_pkg::word_t free_map [lfid_pkg::MAX_WORDS];
    int              open_words;
    grant_t          grant_queue [$];
    int              mismatches;
    int              results_seen;
    int              alloc_count;
    int              full_count;
    int              release_count;
    int              bad_release_count;

    function new();
        foreach (free_map[i])
        begin
            free_map[i] = '0;
        end
        open_words        = 0;
        mismatches        = 0;
        results_seen      = 0;
        alloc_count       = 0;
        full_count        = 0;
        release_count     = 0;
        bad_release_count = 0;
    endfunction

    function void note_request(input logic func, input logic [lfid_pkg::ID_W-1:0] id);
        grant_t exp;
        bit     hit;
        int     widx;
        int     pos;
        exp = '0;
        hit = 1'b0;
        if (func == lfid_pkg::FUNC_ALLOC)
        begin
            for (int w = 0; w < open_words && !hit; w++)
            begin
                for (int b = 0; b < lfid_pkg::WORD_BITS && !hit; b++)
                begin
                    if (free_map[w][b])
                    begin
                        free_map[w][b] = 1'b0;
                        exp.granted    = lfid_pkg::ID_W'(w * lfid_pkg::WORD_BITS + b);
                        hit            = 1'b1;
                    end
                end
            end
            if (!hit)
            begin
                if (open_words < lfid_pkg::MAX_WORDS)
                begin
                    free_map[open_words] = ~lfid_pkg::word_t'(1);
                    exp.granted          = lfid_pkg::ID_W'(open_words * lfid_pkg::WORD_BITS);
                    open_words++;
                end
                else
                begin
                    exp.failed = 1'b1;
                    full_count++;
                end
            end
            if (!exp.failed)
            begin
                alloc_count++;
            end
        end
        else
        begin
            widx = int'(id) / lfid_pkg::WORD_BITS;
            pos  = int'(id) % lfid_pkg::WORD_BITS;
            if (widx >= open_words || widx >= lfid_pkg::MAX_WORDS || free_map[widx][pos])
            begin
                exp.failed = 1'b1;
                bad_release_count++;
            end
            else
            begin
                free_map[widx][pos] = 1'b1;
                release_count++;
            end
        end
        grant_queue.push_back(exp);
    endfunction

    function void check_grant(input logic [15:0] data, input logic failed_bit);
        grant_t exp;
        results_seen++;
        if (grant_queue.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Result %0d arrived with nothing pending: id %0d failed %0b",
                         results_seen, data, failed_bit);
            end
            return;
        end
        exp = grant_queue.pop_front();
        if (data !== 16'(exp.granted) || failed_bit !== exp.failed)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Result %0d: expected id %0d failed %0b, got data 0x%04h failed %0b",
                         results_seen, exp.granted, exp.failed, data,
                         failed_bit);
            end
        end
    endfunction
endclass

module tb_lowest_free_id_allocator;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    id_pool_scoreboard sb;
    int gap_pct;
    int stall_pct;
    int words_sent;
    int quiet_cycles;
    bit quiet_run;

    lowest_free_id_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    task automatic send_request(input logic func, input logic [lfid_pkg::ID_W-1:0] id);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= 16'(id);
        @(negedge clk);
        while (!s_axis_tready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        sb.note_request(func, id);
        words_sent++;
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    function automatic int pick_taken_id();
        int w;
        int b;
        for (int tries = 0; tries < 32; tries++)
        begin
            if (sb.open_words == 0)
            begin
                return -1;
            end
            w = $urandom_range(0, sb.open_words - 1);
            b = $urandom_range(0, lfid_pkg::WORD_BITS - 1);
            if (!sb.free_map[w][b])
            begin
                return w * lfid_pkg::WORD_BITS + b;
            end
        end
        return -1;
    endfunction

    task automatic random_request(input int alloc_pct);
        int roll;
        int id;
        if (!quiet_run)
        begin
            gap_pct   = ((words_sent / 150) % 3 == 0) ? 0 : 12;
            stall_pct = ((words_sent / 150) % 3 == 1) ? 0 : 5;
        end
        if ($urandom_range(0, 99) < alloc_pct)
        begin
            send_request(lfid_pkg::FUNC_ALLOC, lfid_pkg::ID_W'($urandom));
        end
        else
        begin
            roll = $urandom_range(0, 99);
            id   = -1;
            if (roll < 70)
            begin
                id = pick_taken_id();
            end
            else if (roll < 85 && sb.open_words > 0)
            begin
                id = $urandom_range(0, sb.open_words * lfid_pkg::WORD_BITS - 1);
            end
            if (id < 0)
            begin
                id = $urandom_range(0, (1 << lfid_pkg::ID_W) - 1);
            end
            send_request(lfid_pkg::FUNC_RELEASE, lfid_pkg::ID_W'(id));
        end
        sender_gap();
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_grant(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("No word moved for %0d cycles; %0d results still pending.",
                         IDLE_LIMIT, sb.grant_queue.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = lfid_pkg::FUNC_ALLOC;
        rst_n         = 1'b0;
        gap_pct       = 0;
        stall_pct     = 0;
        words_sent    = 0;
        quiet_cycles  = 0;
        quiet_run     = 1'b0;
        sb            = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Releases before anything is open, then the first word and its reuse.
        send_request(lfid_pkg::FUNC_RELEASE, lfid_pkg::ID_W'(0));
        send_request(lfid_pkg::FUNC_RELEASE, lfid_pkg::ID_W'((1 << lfid_pkg::ID_W) - 1));
        send_request(lfid_pkg::FUNC_ALLOC, lfid_pkg::ID_W'((1 << lfid_pkg::ID_W) - 1));
        send_request(lfid_pkg::FUNC_ALLOC, lfid_pkg::ID_W'(0));
        send_request(lfid_pkg::FUNC_ALLOC, lfid_pkg::ID_W'(10'h2AA));
        send_request(lfid_pkg::FUNC_RELEASE, lfid_pkg::ID_W'(1));
        send_request(lfid_pkg::FUNC_RELEASE, lfid_pkg::ID_W'(1));
        send_request(lfid_pkg::FUNC_ALLOC, lfid_pkg::ID_W'(10'h155));
        send_request(lfid_pkg::FUNC_RELEASE, lfid_pkg::ID_W'(lfid_pkg::WORD_BITS - 1));
        send_request(lfid_pkg::FUNC_RELEASE, lfid_pkg::ID_W'(lfid_pkg::WORD_BITS));
        send_request(lfid_pkg::FUNC_RELEASE, lfid_pkg::ID_W'(10'h2AA));
        send_request(lfid_pkg::FUNC_RELEASE, lfid_pkg::ID_W'(0));
        send_request(lfid_pkg::FUNC_ALLOC, lfid_pkg::ID_W'(0));
        send_request(lfid_pkg::FUNC_RELEASE, lfid_pkg::ID_W'(2));
        send_request(lfid_pkg::FUNC_RELEASE, lfid_pkg::ID_W'(0));
        send_request(lfid_pkg::FUNC_ALLOC, lfid_pkg::ID_W'(0));
        send_request(lfid_pkg::FUNC_ALLOC, lfid_pkg::ID_W'(0));

        // Filling every identifier needs about a thousand allocations.
        while (sb.full_count < 4)
        begin
            random_request(100);
        end

        for (int i = 0; i < 30; i++)
        begin
            random_request(40);
        end

        quiet_run = 1'b1;
        gap_pct   = 0;
        stall_pct = 0;
        for (int i = 0; i < 40; i++)
        begin
            random_request(55);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.grant_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words: %0d grants, %0d table-full refusals, %0d releases,",
                 words_sent, sb.alloc_count, sb.full_count, sb.release_count);
        $display("%0d rejected releases; checked %0d results, %0d of %0d words open.",
                 sb.bad_release_count, sb.results_seen, sb.open_words,
                 lfid_pkg::MAX_WORDS);
        if (sb.mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
